@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers for the line clipper
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LCV_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LCV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lcv_pkg.sv @@
// ----------------------------------------------------------------------------
// lcv_pkg
// types, constants and the divider step shared by the line clipper
// ----------------------------------------------------------------------------
`default_nettype none

package lcv_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TB        = 30;
  localparam int SH        = TB - FRAC_BITS;
  localparam int CLIP_QB   = TB + 1;
  localparam int SCR_QB    = TB + 3;
  localparam int REM_W     = 36;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    logic            ok;
    coord_t [3:0]    a;
    coord_t [3:0]    b;
  } seg_t;

  typedef enum logic [2:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_OK     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [13:0] left;
    logic [13:0] top;
    logic [14:0] width;
    logic [14:0] height;
  } vp_cfg_t;

  typedef struct packed {
    logic             q;
    logic [REM_W-1:0] rem;
  } div_res_t;

  function automatic div_res_t div_step(input logic [REM_W-1:0] r,
                                        input logic [REM_W-1:0] d);
    div_res_t res;
    res.q   = (r >= d);
    res.rem = res.q ? (r - d) : r;
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/lcv_plane.sv @@
// ----------------------------------------------------------------------------
// lcv_plane
// clips a segment against one homogeneous plane: distances, pipelined
// restoring divide for the clip factor, lerp multiply and endpoint update
// ----------------------------------------------------------------------------
`default_nettype none

module lcv_plane import lcv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic [2:0] plane,
  input  logic       in_v,
  input  seg_t       in_seg,
  output logic       out_v,
  output seg_t       out_seg
);

  typedef struct packed {
    seg_t               seg;
    logic               mov;
    logic               mv_a;
    logic [REM_W-1:0]   rem;
    logic [REM_W-1:0]   den;
    logic [CLIP_QB-1:0] q;
  } clip_st_t;

  typedef logic signed [63:0] prod_t;

  typedef struct packed {
    seg_t         seg;
    logic         mov;
    logic         mv_a;
    prod_t [3:0]  prod;
  } mul_st_t;

  clip_st_t st_r   [0:CLIP_QB];
  clip_st_t st_nxt [0:CLIP_QB];
  logic     v_r    [0:CLIP_QB];

  mul_st_t  m_r, m_nxt;
  logic     m_v_r;
  seg_t     u_r, u_nxt;
  logic     u_v_r;

  // distances and clip factor operands
  logic [1:0]          ax;
  coord_t              pa, pw, qa, qw;
  logic signed [32:0]  fa, fb;
  logic [32:0]         mag_a, mag_b;
  logic [33:0]         den_sum;

  assign ax = plane[2:1];

  always_comb begin
    pa      = in_seg.a[ax];
    pw      = in_seg.a[3];
    qa      = in_seg.b[ax];
    qw      = in_seg.b[3];
    fa      = plane[0] ? (33'(pw) - 33'(pa)) : (33'(pa) + 33'(pw));
    fb      = plane[0] ? (33'(qw) - 33'(qa)) : (33'(qa) + 33'(qw));
    mag_a   = fa[32] ? 33'(-fa) : 33'(fa);
    mag_b   = fb[32] ? 33'(-fb) : 33'(fb);
    den_sum = 34'(mag_a) + 34'(mag_b);
    st_nxt[0]        = '0;
    st_nxt[0].seg    = in_seg;
    st_nxt[0].seg.ok = in_seg.ok & ~(fa[32] & fb[32]);
    st_nxt[0].mov    = fa[32] ^ fb[32];
    st_nxt[0].mv_a   = fa[32];
    st_nxt[0].rem    = REM_W'(mag_a);
    st_nxt[0].den    = REM_W'(den_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_v;
    end
    if (adv) begin
      st_r[0] <= st_nxt[0];
    end
  end

  // one quotient bit per stage
  for (genvar j = 0; j < CLIP_QB; j++) begin : g_div
    div_res_t res;

    always_comb begin
      res             = div_step(st_r[j].rem, st_r[j].den);
      st_nxt[j+1]     = st_r[j];
      st_nxt[j+1].q[CLIP_QB-1-j] = res.q;
      st_nxt[j+1].rem = {res.rem[REM_W-2:0], 1'b0};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (adv) begin
        v_r[j+1] <= v_r[j];
      end
      if (adv) begin
        st_r[j+1] <= st_nxt[j+1];
      end
    end
  end

  // lerp products
  logic signed [32:0] diff [4];

  always_comb begin
    m_nxt.seg  = st_r[CLIP_QB].seg;
    m_nxt.mov  = st_r[CLIP_QB].mov;
    m_nxt.mv_a = st_r[CLIP_QB].mv_a;
    for (int i = 0; i < 4; i++) begin
      diff[i]       = 33'(coord_t'(st_r[CLIP_QB].seg.b[i]))
                    - 33'(coord_t'(st_r[CLIP_QB].seg.a[i]));
      m_nxt.prod[i] = 64'(diff[i]) * 64'($signed({1'b0, st_r[CLIP_QB].q}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (adv) begin
      m_v_r <= v_r[CLIP_QB];
    end
    if (adv) begin
      m_r <= m_nxt;
    end
  end

  // endpoint update
  prod_t              rnd [4];
  logic signed [33:0] adj [4];
  coord_t             moved [4];

  always_comb begin
    u_nxt = m_r.seg;
    for (int i = 0; i < 4; i++) begin
      rnd[i]   = m_r.prod[i] + (64'sd1 <<< (TB - 1));
      adj[i]   = 34'(rnd[i] >>> TB);
      moved[i] = 32'(34'(coord_t'(m_r.seg.a[i])) + adj[i]);
      if (m_r.seg.ok && m_r.mov) begin
        if (m_r.mv_a) begin
          u_nxt.a[i] = moved[i];
        end else begin
          u_nxt.b[i] = moved[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_v_r <= 1'b0;
    end else if (adv) begin
      u_v_r <= m_v_r;
    end
    if (adv) begin
      u_r <= u_nxt;
    end
  end

  assign out_v   = u_v_r;
  assign out_seg = u_r;

endmodule

`default_nettype wire

@@ rtl/lcv_screen.sv @@
// ----------------------------------------------------------------------------
// lcv_screen
// zero-w reject, perspective ratio by pipelined divide, viewport scale,
// rounding and saturation into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module lcv_screen import lcv_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          out_en,
  input  vp_cfg_t       cfg,
  input  logic          in_v,
  input  seg_t          in_seg,
  output logic          pre_v,
  output logic          out_v,
  output logic          visible,
  output coord_t [3:0]  scr
);

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [REM_W-1:0]  den;
    logic [1:0]        lo;
    logic              neg;
    logic              sat;
    logic [SCR_QB-1:0] q;
  } lane_t;

  typedef struct packed {
    logic        ok;
    lane_t [3:0] ln;
  } div_st_t;

  typedef logic signed [33:0] ratio_t;
  typedef logic signed [49:0] scaled_t;

  div_st_t st_r   [0:SCR_QB];
  div_st_t st_nxt [0:SCR_QB];
  logic    v_r    [0:SCR_QB];

  // numerators and denominators
  logic signed [32:0] n [4];
  logic signed [32:0] d [4];
  logic [32:0]        mn [4];
  logic [32:0]        md [4];

  always_comb begin
    n[0] = 33'(coord_t'(in_seg.a[0])) + 33'(coord_t'(in_seg.a[3]));
    n[1] = 33'(coord_t'(in_seg.a[3])) - 33'(coord_t'(in_seg.a[1]));
    n[2] = 33'(coord_t'(in_seg.b[0])) + 33'(coord_t'(in_seg.b[3]));
    n[3] = 33'(coord_t'(in_seg.b[3])) - 33'(coord_t'(in_seg.b[1]));
    d[0] = {coord_t'(in_seg.a[3]), 1'b0};
    d[1] = d[0];
    d[2] = {coord_t'(in_seg.b[3]), 1'b0};
    d[3] = d[2];
    st_nxt[0]    = '0;
    st_nxt[0].ok = in_seg.ok && (in_seg.a[3] != '0) && (in_seg.b[3] != '0);
    for (int i = 0; i < 4; i++) begin
      mn[i] = n[i][32] ? 33'(-n[i]) : 33'(n[i]);
      md[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
      st_nxt[0].ln[i].rem = REM_W'(mn[i] >> 2);
      st_nxt[0].ln[i].den = REM_W'(md[i]);
      st_nxt[0].ln[i].lo  = mn[i][1:0];
      st_nxt[0].ln[i].neg = n[i][32] ^ d[i][32];
      st_nxt[0].ln[i].sat = REM_W'(mn[i]) >= (REM_W'(md[i]) << 3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_v;
    end
    if (adv) begin
      st_r[0] <= st_nxt[0];
    end
  end

  for (genvar j = 0; j < SCR_QB; j++) begin : g_div
    div_res_t res [4];

    always_comb begin
      st_nxt[j+1] = st_r[j];
      for (int i = 0; i < 4; i++) begin
        res[i] = div_step(st_r[j].ln[i].rem, st_r[j].ln[i].den);
        st_nxt[j+1].ln[i].q[SCR_QB-1-j] = res[i].q;
        st_nxt[j+1].ln[i].rem = {res[i].rem[REM_W-2:0], st_r[j].ln[i].lo[1]};
        st_nxt[j+1].ln[i].lo  = {st_r[j].ln[i].lo[0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (adv) begin
        v_r[j+1] <= v_r[j];
      end
      if (adv) begin
        st_r[j+1] <= st_nxt[j+1];
      end
    end
  end

  // signed, clamped ratio
  localparam logic [SCR_QB-1:0] R_MAX = SCR_QB'(1) << (TB + 2);

  ratio_t [3:0] rr_r, rr_nxt;
  logic         r_ok_r;
  logic         r_v_r;
  logic [SCR_QB-1:0] rmag [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rmag[i]   = (st_r[SCR_QB].ln[i].sat || (st_r[SCR_QB].ln[i].q > R_MAX))
                ? R_MAX : st_r[SCR_QB].ln[i].q;
      rr_nxt[i] = st_r[SCR_QB].ln[i].neg ? -$signed({1'b0, rmag[i]})
                                         :  $signed({1'b0, rmag[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else if (adv) begin
      r_v_r <= v_r[SCR_QB];
    end
    if (adv) begin
      rr_r   <= rr_nxt;
      r_ok_r <= st_r[SCR_QB].ok;
    end
  end

  // scale by viewport size
  scaled_t [3:0] sc_r, sc_nxt;
  logic          s_ok_r;
  logic          s_v_r;
  logic [14:0]   size [4];

  always_comb begin
    size[0] = cfg.width;
    size[1] = cfg.height;
    size[2] = cfg.width;
    size[3] = cfg.height;
    for (int i = 0; i < 4; i++) begin
      sc_nxt[i] = 50'(rr_r[i]) * 50'($signed({1'b0, size[i]}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (adv) begin
      s_v_r <= r_v_r;
    end
    if (adv) begin
      sc_r   <= sc_nxt;
      s_ok_r <= r_ok_r;
    end
  end

  assign pre_v = s_v_r;

  // round, add origin, saturate
  localparam logic signed [50:0] I32_MAX = 51'sd2147483647;
  localparam logic signed [50:0] I32_MIN = -51'sd2147483648;

  coord_t [3:0]       o_r, o_nxt;
  logic               o_ok_r;
  logic               o_v_r;
  logic [13:0]        org [4];
  scaled_t            off [4];
  logic signed [50:0] tot [4];

  always_comb begin
    org[0] = cfg.left;
    org[1] = cfg.top;
    org[2] = cfg.left;
    org[3] = cfg.top;
    for (int i = 0; i < 4; i++) begin
      off[i] = (sc_r[i] + (50'sd1 <<< (SH - 1))) >>> SH;
      tot[i] = $signed(51'(org[i]) << FRAC_BITS) + 51'(off[i]);
      if (!s_ok_r) begin
        o_nxt[i] = '0;
      end else if (tot[i] > I32_MAX) begin
        o_nxt[i] = 32'sh7fffffff;
      end else if (tot[i] < I32_MIN) begin
        o_nxt[i] = 32'sh80000000;
      end else begin
        o_nxt[i] = 32'(tot[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (out_en) begin
      o_v_r <= s_v_r;
    end
    if (out_en) begin
      o_r    <= o_nxt;
      o_ok_r <= s_ok_r;
    end
  end

  assign out_v   = o_v_r;
  assign visible = o_ok_r;
  assign scr     = o_r;

endmodule

`default_nettype wire

@@ rtl/homogeneous_line_clip_viewport_top.sv @@
// ----------------------------------------------------------------------------
// homogeneous_line_clip_viewport_top
// clip-space line clipper against six planes with viewport mapping
// ----------------------------------------------------------------------------
// usage
// - in channel: one segment per item, two clip-space endpoints in Q16.16
// - out channel: visible flag in tuser, four screen coordinates in tdata
// - cfg channel: viewport registers, always ready, write only when idle
// - 241 register stages from input to output: six plane units of 34 stages
//   each (31 of them the clip-factor divider, one bit per stage) and 37
//   stages of screen mapping (33-bit divider)
// - throughput is one item per cycle unless the receiver stalls; all stages
//   but the output register share one advance enable; when the receiver
//   stalls, a result waits in the output register, and the stages before it
//   advance and take items until the stage before it fills and in_tready drops
// - reset clears all valid bits and sets the viewport registers to left 0,
//   top 0, width 1, height 1 and invalid, so every item comes out hidden
// - a hidden item carries zeros in all screen fields
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module homogeneous_line_clip_viewport_top import lcv_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // start_x, start_y, start_z, start_w, end_x, end_y, end_z, end_w
  input  logic [255:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // screen_ax, screen_ay, screen_bx, screen_by
  output logic [127:0]  out_tdata,
  // visible
  output logic          out_tuser,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [14:0]   cfg_data
);

  vp_cfg_t cfg_r;
  logic    vp_ok_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left   <= '0;
      cfg_r.top    <= '0;
      cfg_r.width  <= 15'd1;
      cfg_r.height <= 15'd1;
      vp_ok_r      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LEFT:   cfg_r.left   <= cfg_data[13:0];
        REG_TOP:    cfg_r.top    <= cfg_data[13:0];
        REG_WIDTH:  cfg_r.width  <= cfg_data;
        REG_HEIGHT: cfg_r.height <= cfg_data;
        REG_OK:     vp_ok_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stall control
  logic adv, out_en, pre_v;

  assign out_en    = !out_tvalid || out_tready;
  assign adv       = out_en || !pre_v;
  assign in_tready = adv;

  seg_t ch_seg [0:6];
  logic ch_v   [0:6];

  always_comb begin
    ch_seg[0].ok = vp_ok_r && (cfg_r.width != '0) && (cfg_r.height != '0);
    ch_seg[0].a  = in_tdata[127:0];
    ch_seg[0].b  = in_tdata[255:128];
    ch_v[0]      = in_tvalid;
  end

  for (genvar k = 0; k < 6; k++) begin : g_plane
    lcv_plane u_plane (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .plane   (3'(k)),
      .in_v    (ch_v[k]),
      .in_seg  (ch_seg[k]),
      .out_v   (ch_v[k+1]),
      .out_seg (ch_seg[k+1])
    );
  end

  coord_t [3:0] scr;

  lcv_screen u_screen (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .out_en  (out_en),
    .cfg     (cfg_r),
    .in_v    (ch_v[6]),
    .in_seg  (ch_seg[6]),
    .pre_v   (pre_v),
    .out_v   (out_tvalid),
    .visible (out_tuser),
    .scr     (scr)
  );

  assign out_tdata = scr;

  `LCV_ASSERT_NOW(a_hidden_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata == '0, "hidden item with nonzero coordinates")
  `LCV_ASSERT_NOW(a_stall_cause, clk, rst_n, !in_tready, out_tvalid && !out_tready, "input stalled without output back-pressure")
  `LCV_ASSERT_NEXT(a_drain, clk, rst_n, out_tvalid && !out_tready && pre_v, out_tvalid && pre_v, "pipeline moved while output held")

endmodule

`default_nettype wire
